@@ src/kmer_set_insert_and_map_defines.svh @@
// Assertion macros for the k-mer set block.
`ifndef KMER_SET_INSERT_AND_MAP_DEFINES_SVH
`define KMER_SET_INSERT_AND_MAP_DEFINES_SVH

// Clocked on clk_i, disabled while rst_ni is low.
`define KMSIM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kmsim assertion failed");

// Same, checked only while a result is offered.
`define KMSIM_ASSERT_OUT(lbl, prop) \
  `KMSIM_ASSERT(lbl, out_valid_i |-> (prop))

`endif

@@ src/kmsim_pkg.sv @@
// ----------------------------------------------------------------------------
// kmsim_pkg
// Types, codes and constants of the k-mer set insert and map block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsim_pkg;

  localparam int unsigned CAPACITY_DEF    = 65536;
  localparam int unsigned HASH_SLOTS_DEF  = 131072;
  localparam int unsigned MAX_PENDING_DEF = 1024;
  localparam int unsigned MAX_BASES       = 32;
  localparam int unsigned K_LIMIT         = (MAX_BASES < 32) ? MAX_BASES : 32;

  localparam int unsigned KMER_W    = 64;
  localparam int unsigned KLEN_W    = 6;
  localparam int unsigned NODE_W    = 17;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned BASE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd31;
  localparam logic [KMER_W-1:0] GOLDEN     = 64'h9E3779B97F4A7C15;

  localparam logic [FUNC_W-1:0] FUNC_ADD       = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MAP_CANON = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MAP_PLAIN = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL   = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_POP,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_MOD,
    ST_PROBE,
    ST_SLOT,
    ST_KEY,
    ST_INS,
    ST_FIN
  } state_e;

  function automatic logic [KMER_W-1:0] revcomp(input logic [KMER_W-1:0] x,
                                                input logic [KLEN_W-1:0] k);
    logic [KMER_W-1:0] nx;
    logic [KMER_W-1:0] r;
    logic [6:0]        sh;
    nx = ~x;
    for (int i = 0; i < 32; i++) begin
      r[2*i +: 2] = nx[KMER_W-2-2*i +: 2];
    end
    sh = 7'd64 - {k, 1'b0};
    return r >> sh;
  endfunction

endpackage

`default_nettype wire

@@ src/kmsim_in_if.sv @@
// ----------------------------------------------------------------------------
// kmsim_in_if
// Base item channel: valid, ready and the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmsim_in_if;
  import kmsim_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BASE_W-1:0] base;
  logic              base_valid;
  logic              seq_start;
  logic              skip;
  modport source (output valid, func, base, base_valid, seq_start, skip, input ready);
  modport sink   (input valid, func, base, base_valid, seq_start, skip, output ready);
endinterface

`default_nettype wire

@@ src/kmsim_out_if.sv @@
// ----------------------------------------------------------------------------
// kmsim_out_if
// Result channel: valid, ready and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmsim_out_if;
  import kmsim_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node;
  logic              window_full;
  logic              inserted;
  logic              store_full;
  logic              pending_overflow;
  logic              pending_empty;
  modport source (output valid, node, window_full, inserted, store_full,
                  pending_overflow, pending_empty, input ready);
  modport sink   (input valid, node, window_full, inserted, store_full,
                  pending_overflow, pending_empty, output ready);
endinterface

`default_nettype wire

@@ src/kmsim_cfg_if.sv @@
// ----------------------------------------------------------------------------
// kmsim_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmsim_cfg_if;
  import kmsim_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/kmer_set_insert_and_map.sv @@
// ----------------------------------------------------------------------------
// kmer_set_insert_and_map
// Rolling k-mer window with an insertion-ordered set of distinct k-mers,
// found through a linear-probing hash index, and a reverse complement stack.
//
//   channel   dir   handshake      payload
//   cfg_i     in    valid/ready    index, data
//   in_i      in    valid/ready    func, base, base_valid, seq_start, skip
//   out_o     out   valid/ready    node, window_full, inserted, store_full,
//                                  pending_overflow, pending_empty
//
// An item without lookup goes from ST_PREP to ST_FIN; otherwise its key is
// hashed and probed, ST_INS inserts a new key and ST_POP pops one on a flush;
// a non power of two slot count adds a serial modulo in ST_MOD.
// The hash is one shared 32x32 multiplier over ST_MUL0 to ST_MUL2; each probe
// costs a slot read and, for an occupied slot, a key read, both from RAMs
// with registered read data. After reset every slot of the hash index is
// cleared; in_i is not ready meanwhile. cfg_i is always ready. A result waits
// in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_set_insert_and_map #(
  parameter int unsigned CAPACITY    = kmsim_pkg::CAPACITY_DEF,
  parameter int unsigned HASH_SLOTS  = kmsim_pkg::HASH_SLOTS_DEF,
  parameter int unsigned MAX_PENDING = kmsim_pkg::MAX_PENDING_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kmsim_cfg_if.sink  cfg_i,
  kmsim_in_if.sink   in_i,
  kmsim_out_if.source out_o
);
  import kmsim_pkg::*;

  localparam int unsigned SW   = $clog2(HASH_SLOTS);
  localparam int unsigned NCW  = $clog2(HASH_SLOTS + 1);
  localparam int unsigned NW   = $clog2(CAPACITY + 1);
  localparam int unsigned SAW  = $clog2(CAPACITY);
  localparam int unsigned PW   = $clog2(MAX_PENDING + 1);
  localparam int unsigned PAW  = $clog2(MAX_PENDING);
  localparam bit          POW2 = ((HASH_SLOTS & (HASH_SLOTS - 1)) == 0);
  localparam logic [SW:0]    SLOTS_X = (SW+1)'(HASH_SLOTS);
  localparam logic [SW-1:0]  SLOT_LAST = SW'(HASH_SLOTS - 1);
  localparam logic [NCW-1:0] PROBE_MAX = NCW'(HASH_SLOTS);
  localparam logic [NW-1:0]  CAP_N = NW'(CAPACITY);
  localparam logic [PW-1:0]  PEND_MAX = PW'(MAX_PENDING);

  state_e state_q, state_d;

  logic [KLEN_W-1:0] klen_q, klen_d;
  logic              canon_q, canon_d;
  logic [KMER_W-1:0] win_q, win_d;
  logic [KLEN_W-1:0] vr_q, vr_d;
  logic              full_q, full_d;
  logic [KLEN_W-1:0] k_q, k_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic              skip_q, skip_d;
  logic              ins_q, ins_d;
  logic              push_q, push_d;
  logic [KMER_W-1:0] key_q, key_d;
  logic [KMER_W-1:0] rc_q, rc_d;
  logic [KMER_W-1:0] acc_q, acc_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [5:0]        bit_q, bit_d;
  logic [NCW-1:0]    n_q, n_d;
  logic [SW-1:0]     fs_q, fs_d;
  logic [NW-1:0]     v_q, v_d;
  logic [NW-1:0]     node_q, node_d;
  logic              new_q, new_d;
  logic              sfull_q, sfull_d;
  logic              ovf_q, ovf_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     pend_q, pend_d;
  logic [SW-1:0]     clr_q, clr_d;

  logic              ov_q, ov_d;
  logic [NODE_W-1:0] on_q, on_d;
  logic              owf_q, owf_d;
  logic              oins_q, oins_d;
  logic              osf_q, osf_d;
  logic              oovf_q, oovf_d;
  logic              oemp_q, oemp_d;

  logic [KLEN_W-1:0] k_eff;
  logic [KMER_W-1:0] kmask;
  logic [KLEN_W-1:0] vr_c;
  logic [KMER_W-1:0] win_c;
  logic [KMER_W-1:0] rc_c;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [KMER_W-1:0] mix_c;
  logic [SW:0]       mod_t;
  logic [SW-1:0]     slot_nx;
  logic [NCW-1:0]    n_nx;

  logic              h_we;
  logic [SW-1:0]     h_waddr;
  logic [NW-1:0]     h_wdata;
  logic [NW-1:0]     h_rdata;
  logic              s_we;
  logic [SAW-1:0]    s_raddr;
  logic [KMER_W-1:0] s_rdata;
  logic              p_we;
  logic [PAW-1:0]    p_waddr;
  logic [PAW-1:0]    p_raddr;
  logic [KMER_W-1:0] p_rdata;

  logic              accept;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid            = ov_q;
  assign out_o.node             = on_q;
  assign out_o.window_full      = owf_q;
  assign out_o.inserted         = oins_q;
  assign out_o.store_full       = osf_q;
  assign out_o.pending_overflow = oovf_q;
  assign out_o.pending_empty    = oemp_q;

  always_comb begin
    if (klen_q == '0) begin
      k_eff = KLEN_W'(1);
    end else if (klen_q > KLEN_W'(K_LIMIT)) begin
      k_eff = KLEN_W'(K_LIMIT);
    end else begin
      k_eff = klen_q;
    end
    kmask = (k_eff >= KLEN_W'(32)) ? {KMER_W{1'b1}} : ~({KMER_W{1'b1}} << {k_eff, 1'b0});
    vr_c  = (vr_q > k_eff) ? k_eff : vr_q;
    win_c = win_q;
    if (in_i.func != FUNC_FLUSH) begin
      if (in_i.seq_start) begin
        win_c = '0;
        vr_c  = '0;
      end
      if (in_i.base_valid) begin
        win_c = ((win_c << 2) | KMER_W'(in_i.base)) & kmask;
        if (vr_c < k_eff) begin
          vr_c = vr_c + 1'b1;
        end
      end else begin
        vr_c = '0;
      end
    end
    win_c = win_c & kmask;
  end

  assign rc_c  = revcomp(win_q, k_q);
  assign mul_a = (state_q == ST_MUL2) ? key_q[63:32] : key_q[31:0];
  assign mul_b = (state_q == ST_MUL1) ? GOLDEN[63:32] : GOLDEN[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign mix_c = acc_q ^ (acc_q >> 29);
  assign mod_t = {rem_q, acc_q[bit_q]};
  assign slot_nx = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
  assign n_nx    = n_q + 1'b1;

  always_comb begin
    state_d = state_q;
    klen_d = klen_q;   canon_d = canon_q;
    win_d = win_q;     vr_d = vr_q;       full_d = full_q;   k_d = k_q;
    func_d = func_q;   skip_d = skip_q;   ins_d = ins_q;     push_d = push_q;
    key_d = key_q;     rc_d = rc_q;       acc_d = acc_q;
    slot_d = slot_q;   rem_d = rem_q;     bit_d = bit_q;     n_d = n_q;
    fs_d = fs_q;       v_d = v_q;
    node_d = node_q;   new_d = new_q;     sfull_d = sfull_q; ovf_d = ovf_q;
    cnt_d = cnt_q;     pend_d = pend_q;   clr_d = clr_q;
    ov_d = ov_q;       on_d = on_q;       owf_d = owf_q;     oins_d = oins_q;
    osf_d = osf_q;     oovf_d = oovf_q;   oemp_d = oemp_q;
    h_we = 1'b0;       h_waddr = fs_q;    h_wdata = cnt_q + 1'b1;
    s_we = 1'b0;       s_raddr = SAW'(h_rdata - 1'b1);
    p_we = 1'b0;       p_waddr = PAW'(pend_q);  p_raddr = PAW'(pend_q - 1'b1);

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_KMER_LENGTH: klen_d  = cfg_i.data[KLEN_W-1:0];
        CFG_CANONICAL:   canon_d = cfg_i.data[0];
        default: ;
      endcase
    end

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == SLOT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          win_d   = win_c;
          vr_d    = vr_c;
          full_d  = (vr_c >= k_eff);
          k_d     = k_eff;
          func_d  = in_i.func;
          skip_d  = in_i.skip;
          node_d  = '0;
          new_d   = 1'b0;
          sfull_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        rc_d    = rc_c;
        key_d   = win_q;
        push_d  = 1'b0;
        ins_d   = 1'b0;
        state_d = ST_FIN;
        case (func_q) inside
          FUNC_ADD: begin
            if (full_q && !skip_q) begin
              ins_d   = 1'b1;
              push_d  = canon_q;
              state_d = ST_MUL0;
            end
          end
          FUNC_MAP_CANON, FUNC_MAP_PLAIN: begin
            if (full_q) begin
              if (func_q == FUNC_MAP_CANON && canon_q && rc_c < win_q) begin
                key_d = rc_c;
              end
              state_d = ST_MUL0;
            end
          end
          default: begin
            if (pend_q != '0) begin
              pend_d  = pend_q - 1'b1;
              ins_d   = 1'b1;
              state_d = ST_POP;
            end
          end
        endcase
      end
      ST_POP: begin
        key_d   = p_rdata;
        state_d = ST_MUL0;
      end
      ST_MUL0: begin
        acc_d   = prod;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d = ST_MIX;
      end
      ST_MIX: begin
        acc_d = mix_c;
        n_d   = '0;
        if (POW2) begin
          slot_d  = mix_c[SW-1:0];
          state_d = ST_PROBE;
        end else begin
          rem_d   = '0;
          bit_d   = 6'd63;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        rem_d = (mod_t >= SLOTS_X) ? SW'(mod_t - SLOTS_X) : mod_t[SW-1:0];
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          slot_d  = rem_d;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_d = ST_SLOT;
      end
      ST_SLOT: begin
        v_d = h_rdata;
        if (h_rdata == '0) begin
          fs_d    = slot_q;
          state_d = ins_q ? ST_INS : ST_FIN;
        end else if (h_rdata <= CAP_N) begin
          state_d = ST_KEY;
        end else begin
          slot_d = slot_nx;
          n_d    = n_nx;
          if (n_nx == PROBE_MAX) begin
            sfull_d = ins_q;
            state_d = ST_FIN;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end
      ST_KEY: begin
        if (s_rdata == key_q) begin
          node_d  = v_q;
          state_d = ST_FIN;
        end else begin
          slot_d = slot_nx;
          n_d    = n_nx;
          if (n_nx == PROBE_MAX) begin
            sfull_d = ins_q;
            state_d = ST_FIN;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end
      ST_INS: begin
        if (cnt_q >= CAP_N) begin
          sfull_d = 1'b1;
        end else begin
          s_we   = 1'b1;
          h_we   = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          node_d = cnt_q + 1'b1;
          new_d  = 1'b1;
          if (push_q) begin
            if (pend_q < PEND_MAX) begin
              p_we   = 1'b1;
              pend_d = pend_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          on_d    = NODE_W'(node_q);
          owf_d   = full_q;
          oins_d  = new_q;
          osf_d   = sfull_q;
          oovf_d  = ovf_q;
          oemp_d  = (pend_q == '0);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      klen_q  <= KLEN_RESET;
      canon_q <= 1'b0;
      win_q   <= '0;
      vr_q    <= '0;
      cnt_q   <= '0;
      pend_q  <= '0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      klen_q  <= klen_d;
      canon_q <= canon_d;
      win_q   <= win_d;
      vr_q    <= vr_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    full_q  <= full_d;   k_q    <= k_d;     func_q <= func_d;  skip_q  <= skip_d;
    ins_q   <= ins_d;    push_q <= push_d;  key_q  <= key_d;   rc_q    <= rc_d;
    acc_q   <= acc_d;    slot_q <= slot_d;  rem_q  <= rem_d;   bit_q   <= bit_d;
    n_q     <= n_d;      fs_q   <= fs_d;    v_q    <= v_d;     node_q  <= node_d;
    new_q   <= new_d;    sfull_q <= sfull_d; ovf_q <= ovf_d;
    on_q    <= on_d;     owf_q  <= owf_d;   oins_q <= oins_d;  osf_q   <= osf_d;
    oovf_q  <= oovf_d;   oemp_q <= oemp_d;
  end

  kmsim_ram #(.WIDTH(NW), .DEPTH(HASH_SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (slot_q),
    .rdata_o (h_rdata)
  );

  kmsim_ram #(.WIDTH(KMER_W), .DEPTH(CAPACITY)) u_store (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (SAW'(cnt_q)),
    .wdata_i (key_q),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  kmsim_ram #(.WIDTH(KMER_W), .DEPTH(MAX_PENDING)) u_stack (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (rc_q),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

endmodule

`default_nettype wire

@@ src/kmsim_ram.sv @@
// ----------------------------------------------------------------------------
// kmsim_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsim_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/kmsim_checker.sv @@
// ----------------------------------------------------------------------------
// kmsim_checker
// Port-level checks on the result channel of the k-mer set block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kmer_set_insert_and_map_defines.svh"

module kmsim_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [16:0] node_i,
  input wire logic        inserted_i,
  input wire logic        store_full_i,
  input wire logic        pending_overflow_i
);

  `KMSIM_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(node_i))
  `KMSIM_ASSERT_OUT(a_new_node, !inserted_i || node_i != 17'd0)
  `KMSIM_ASSERT_OUT(a_full_refused, !store_full_i || (node_i == 17'd0 && !inserted_i))
  `KMSIM_ASSERT_OUT(a_ovf_on_insert, !pending_overflow_i || inserted_i)

endmodule

bind kmer_set_insert_and_map kmsim_checker u_kmsim_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .node_i             (out_o.node),
  .inserted_i         (out_o.inserted),
  .store_full_i       (out_o.store_full),
  .pending_overflow_i (out_o.pending_overflow)
);

`default_nettype wire
